[rtl/nds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_pkg
// shared types, register codes and byte helpers for the bracket-aware
// delimiter splitter
// ----------------------------------------------------------------------------
package nds_pkg;

  // configuration port
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 32;
  localparam int DLEN_W         = 3;
  localparam int DELIM_WORD_W   = 32;
  localparam int DELIM_WORD_BYTES = DELIM_WORD_W / 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_LEN   = 1'b0,
    REG_DELIM_BYTES = 1'b1
  } cfg_reg_t;

  localparam logic [DLEN_W-1:0]       DELIM_LEN_RESET   = 3'd1;
  localparam logic [DELIM_WORD_W-1:0] DELIM_BYTES_RESET = 32'd44;

  // bracket characters; "+I[" needs no case of its own, its '[' opens a group
  localparam logic [7:0] SQ_OPEN     = 8'h5B;
  localparam logic [7:0] SQ_CLOSE    = 8'h5D;
  localparam logic [7:0] CURLY_OPEN  = 8'h7B;
  localparam logic [7:0] CURLY_CLOSE = 8'h7D;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_end;
    logic       string_end;
    logic       parse_error;
  } result_t;

  function automatic logic is_opener(input logic [7:0] c);
    return (c == SQ_OPEN) || (c == CURLY_OPEN);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == SQ_CLOSE) || (c == CURLY_CLOSE);
  endfunction

  // delimiter bytes past the register width read as zero
  function automatic logic [7:0] delim_byte(input logic [DELIM_WORD_W-1:0] word,
                                            input int k);
    logic [7:0] b;
    b = 8'h00;
    if (k < DELIM_WORD_BYTES) begin
      b = word[8*k +: 8];
    end
    return b;
  endfunction

  function automatic result_t byte_result(input logic [7:0] c);
    result_t r;
    r = '0;
    r.out_byte = c;
    r.has_byte = 1'b1;
    return r;
  endfunction

  function automatic result_t mark_result(input logic te, input logic se, input logic pe);
    result_t r;
    r = '0;
    r.token_end   = te;
    r.string_end  = se;
    r.parse_error = pe;
    return r;
  endfunction

endpackage

[rtl/nested_delimiter_splitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_delimiter_splitter_unit
// splits a byte string into tokens at a configured delimiter of up to
// DELIM_MAX bytes, never inside a [ ] or { } group
// ----------------------------------------------------------------------------
// usage
//   input channel: one string byte per transfer (in_byte, is_last marks the
//   final byte). output channel: one result per transfer, either a token
//   byte (has_byte), a token end, a string end or an error mark.
//   delim_len (index 0) and delim_bytes (index 1) are written through
//   cfg_we / cfg_index / cfg_data while no string is in flight.
// timing
//   a taken byte waits in the input register, and its results are written
//   into the result queue as it leaves; the queue head drives out_valid.
//   one byte per cycle is taken while the queue has room. a byte that
//   releases held partial-delimiter bytes, or ends a string, yields up to
//   DELIM_MAX + 1 results, drained one per cycle while out_stall is low
//   from a result queue of FIFO_DEPTH entries; in_stall rises only while
//   it lacks room for a full batch, so output stalls back up into in_stall.
// reset
//   clears the queue, the nesting state and the held bytes; delim_len
//   comes up as 1 and the delimiter as a comma.
// ----------------------------------------------------------------------------
module nested_delimiter_splitter_unit
  import nds_pkg::*;
#(
  parameter int DELIM_MAX   = 4,
  parameter int STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // string bytes
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  is_last,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  has_byte,
  output logic                  token_end,
  output logic                  string_end,
  output logic                  parse_error,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // largest batch one byte can produce, and a queue of at least two batches
  localparam int RES_N      = DELIM_MAX + 1;
  localparam int RW         = $clog2(RES_N + 1);
  localparam int FIFO_DEPTH = 2 ** $clog2(2 * RES_N);

  logic [DLEN_W-1:0]       delim_len;
  logic [DELIM_WORD_W-1:0] delim_bytes;

  logic [RW-1:0]           wr_count;
  result_t                 wr_data [RES_N];
  logic                    fifo_room;
  logic                    fifo_nonempty;
  logic                    pop;
  result_t                 head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_len   <= DELIM_LEN_RESET;
      delim_bytes <= DELIM_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELIM_LEN: begin
          delim_len <= cfg_data[DLEN_W-1:0];
        end
        REG_DELIM_BYTES: begin
          delim_bytes <= cfg_data[DELIM_WORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input register, bracket stack and delimiter matching
  nds_parser #(
    .DELIM_MAX   (DELIM_MAX),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .is_last     (is_last),
    .delim_len   (delim_len),
    .delim_bytes (delim_bytes),
    .fifo_room   (fifo_room),
    .wr_count    (wr_count),
    .wr_data     (wr_data)
  );

  // a result transfer pops the queue head
  assign pop = fifo_nonempty && !out_stall;

  nds_rfifo #(
    .WR_N  (RES_N),
    .DEPTH (FIFO_DEPTH)
  ) u_rfifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_data  (wr_data),
    .pop      (pop),
    .head     (head),
    .nonempty (fifo_nonempty),
    .room     (fifo_room)
  );

  // the head entry is stored and stays put until it is taken
  assign out_valid   = fifo_nonempty;
  assign out_byte    = head.out_byte;
  assign has_byte    = head.has_byte;
  assign token_end   = head.token_end;
  assign string_end  = head.string_end;
  assign parse_error = head.parse_error;

endmodule

[rtl/nds_rfifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_rfifo
// result queue: takes a batch of results per cycle, hands out one per cycle
// ----------------------------------------------------------------------------
module nds_rfifo
  import nds_pkg::*;
#(
  parameter int WR_N  = 5,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [$clog2(WR_N+1)-1:0]  wr_count,
  input  result_t                    wr_data [WR_N],
  input  logic                       pop,
  output result_t                    head,
  output logic                       nonempty,
  output logic                       room
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = $clog2(WR_N + 1);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW-1:0]   count;

  // room for a whole batch, judged on the registered fill level
  assign room     = count <= CW'(DEPTH - WR_N);
  assign nonempty = count != '0;
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(wr_count);
      rptr  <= rptr + AW'(pop);
      count <= count + CW'(wr_count) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < WR_N; k++) begin
      if (NW'(k) < wr_count) begin
        mem[wptr + AW'(k)] <= wr_data[k];
      end
    end
  end

endmodule

[rtl/nds_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_parser
// input register, per-string state and the single-pass split of one byte
// into its batch of results
// ----------------------------------------------------------------------------
module nds_parser
  import nds_pkg::*;
#(
  parameter int DELIM_MAX   = 4,
  parameter int STACK_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  input  logic                              is_last,
  input  logic [DLEN_W-1:0]                 delim_len,
  input  logic [DELIM_WORD_W-1:0]           delim_bytes,
  input  logic                              fifo_room,
  output logic [$clog2(DELIM_MAX+2)-1:0]    wr_count,
  output result_t                           wr_data [DELIM_MAX+1]
);

  localparam int RES_N = DELIM_MAX + 1;
  localparam int RW    = $clog2(RES_N + 1);
  localparam int RIW   = $clog2(RES_N);
  localparam int QW    = $clog2(DELIM_MAX + 1);
  localparam int PCW   = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
  localparam int PN    = (DELIM_MAX > 1) ? DELIM_MAX - 1 : 1;
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int SIW   = $clog2(STACK_DEPTH);

  // input register
  logic                   hold_valid;
  logic [7:0]             hold_byte;
  logic                   hold_last;
  logic                   advance;

  // per-string state
  logic [DW-1:0]          depth;
  logic [STACK_DEPTH-1:0] stack;
  logic [7:0]             pend [PN];
  logic [PCW-1:0]         pcount;
  logic                   tne;
  logic                   disc;

  // delimiter match
  logic [QW-1:0]          lim;
  logic [QW-1:0]          qn;
  logic [7:0]             q [DELIM_MAX];
  logic [QW-1:0]          rem [DELIM_MAX];
  logic [DELIM_MAX-1:0]   pre;
  logic [DELIM_MAX-1:0]   full;

  // walk over the queued bytes
  logic [DW-1:0]          depth_next;
  logic [STACK_DEPTH-1:0] stack_next;
  logic [7:0]             pend_next [PN];
  logic [PCW-1:0]         pcount_next;
  logic                   tne_next;
  logic                   disc_next;
  logic                   done;
  logic                   at_top;
  logic [7:0]             cur;
  logic [DW-1:0]          top_idx;
  result_t                res [RES_N];
  logic [RW-1:0]          cnt;

  assign advance  = hold_valid && fifo_room;
  assign in_stall = hold_valid && !fifo_room;
  assign wr_count = advance ? cnt : '0;
  assign wr_data  = res;

  // pending bytes plus the new byte, and which positions start a delimiter
  always_comb begin
    if (int'(delim_len) > DELIM_MAX) begin
      lim = QW'(DELIM_MAX);
    end else begin
      lim = QW'(delim_len);
    end
    for (int i = 0; i < DELIM_MAX; i++) begin
      q[i] = 8'h00;
    end
    for (int i = 0; i < PN; i++) begin
      if (PCW'(i) < pcount) begin
        q[i] = pend[i];
      end
    end
    q[pcount] = hold_byte;
    qn = QW'(pcount) + QW'(1);
    for (int j = 0; j < DELIM_MAX; j++) begin
      rem[j] = qn - QW'(j);
      pre[j] = (QW'(j) < qn) && (rem[j] <= lim);
      for (int i = 0; i < DELIM_MAX - j; i++) begin
        if ((QW'(i) < rem[j]) && (q[j+i] != delim_byte(delim_bytes, i))) begin
          pre[j] = 1'b0;
        end
      end
      full[j] = pre[j] && (rem[j] == lim);
    end
  end

  always_comb begin
    depth_next  = depth;
    stack_next  = stack;
    pend_next   = pend;
    pcount_next = pcount;
    tne_next    = tne;
    disc_next   = disc;
    done        = 1'b0;
    at_top      = 1'b0;
    cur         = 8'h00;
    top_idx     = '0;
    cnt         = '0;
    for (int k = 0; k < RES_N; k++) begin
      res[k] = '0;
    end

    if (disc) begin
      // dropping the rest of a bad string
      if (hold_last) begin
        res[0] = mark_result(1'b0, 1'b1, 1'b1);
        cnt    = RW'(1);
      end
    end else if (lim == '0) begin
      // splitting off: held bytes first, then the new byte
      for (int i = 0; i < PN; i++) begin
        if (PCW'(i) < pcount) begin
          res[i] = byte_result(pend[i]);
        end
      end
      res[RIW'(pcount)] = byte_result(hold_byte);
      cnt         = RW'(pcount) + RW'(1);
      tne_next    = 1'b1;
      pcount_next = '0;
      if (hold_last) begin
        res[cnt[RIW-1:0]] = mark_result(1'b1, 1'b1, 1'b0);
        cnt = cnt + RW'(1);
      end
    end else begin
      pcount_next = '0;
      for (int j = 0; j < DELIM_MAX; j++) begin
        if ((QW'(j) < qn) && !done && !disc_next) begin
          cur    = q[j];
          at_top = (depth_next == '0);
          if (!at_top) begin
            if (is_opener(cur)) begin
              if (depth_next >= DW'(STACK_DEPTH)) begin
                res[j]      = mark_result(1'b0, 1'b0, 1'b1);
                cnt         = cnt + RW'(1);
                disc_next   = 1'b1;
                pcount_next = '0;
              end else begin
                stack_next[depth_next[SIW-1:0]] = (cur == CURLY_OPEN);
                depth_next = depth_next + DW'(1);
                res[j]     = byte_result(cur);
                cnt        = cnt + RW'(1);
                tne_next   = 1'b1;
              end
            end else if (is_closer(cur)) begin
              top_idx = depth_next - DW'(1);
              if (stack_next[top_idx[SIW-1:0]] != (cur == CURLY_CLOSE)) begin
                res[j]      = mark_result(1'b0, 1'b0, 1'b1);
                cnt         = cnt + RW'(1);
                disc_next   = 1'b1;
                pcount_next = '0;
              end else begin
                depth_next = top_idx;
                if (top_idx == '0) begin
                  // group closed: the closer is seen again at top level
                  at_top = 1'b1;
                end else begin
                  res[j]   = byte_result(cur);
                  cnt      = cnt + RW'(1);
                  tne_next = 1'b1;
                end
              end
            end else begin
              res[j]   = byte_result(cur);
              cnt      = cnt + RW'(1);
              tne_next = 1'b1;
            end
          end
          if (at_top) begin
            if (full[j]) begin
              res[j]   = mark_result(1'b1, 1'b0, 1'b0);
              cnt      = cnt + RW'(1);
              tne_next = 1'b0;
              done     = 1'b1;
            end else if (pre[j] && !hold_last) begin
              // could still become a delimiter: hold the tail
              for (int i = 0; i < PN; i++) begin
                if (j + i < DELIM_MAX) begin
                  pend_next[i] = q[j+i];
                end
              end
              pcount_next = PCW'(rem[j]);
              done        = 1'b1;
            end else begin
              if (is_opener(cur)) begin
                stack_next[0] = (cur == CURLY_OPEN);
                depth_next    = DW'(1);
              end
              res[j]   = byte_result(cur);
              cnt      = cnt + RW'(1);
              tne_next = 1'b1;
            end
          end
        end
      end
      if (hold_last) begin
        if (disc_next || (depth_next != '0)) begin
          res[cnt[RIW-1:0]] = mark_result(1'b0, 1'b1, 1'b1);
        end else begin
          res[cnt[RIW-1:0]] = mark_result(tne_next, 1'b1, 1'b0);
        end
        cnt = cnt + RW'(1);
      end
    end

    if (hold_last) begin
      depth_next  = '0;
      pcount_next = '0;
      tne_next    = 1'b0;
      disc_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      depth      <= '0;
      stack      <= '0;
      pcount     <= '0;
      tne        <= 1'b0;
      disc       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        depth  <= depth_next;
        stack  <= stack_next;
        pcount <= pcount_next;
        tne    <= tne_next;
        disc   <= disc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= in_byte;
      hold_last <= is_last;
    end
    if (advance) begin
      pend <= pend_next;
    end
  end

endmodule

[tb/sv/nested_delimiter_splitter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_delimiter_splitter_unit_test
// self-checking bench for the bracket-aware delimiter splitter: a byte
// driver and a result monitor with random idling on both sides, an in-bench
// tokenizer that predicts every result, and phases over several delimiter
// settings (zero, one to four bytes, over-long length, all-zero and all-ones
// delimiter bytes, length change while delimiter bytes are held)
// ----------------------------------------------------------------------------
module nested_delimiter_splitter_unit_test;
  import nds_pkg::*;

  localparam int DELIM_MAX   = 4;
  localparam int STACK_DEPTH = 16;
  // cycles with no transfer on either side before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // cycles allowed for a byte that causes no result to clear the pipeline
  localparam int SETTLE_CYCLES = 20;
  // length of the forced output hold that backs the block up into in_stall
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } string_byte_t;

  // outcome of one byte seen inside a bracket group
  typedef enum logic [1:0] {
    GROUP_HELD,
    GROUP_CLOSED,
    GROUP_FAULT
  } group_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte = 8'h00;
  logic                  is_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  has_byte;
  logic                  token_end;
  logic                  string_end;
  logic                  parse_error;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DELIM_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nested_delimiter_splitter_unit #(
    .DELIM_MAX  (DELIM_MAX),
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .token_end  (token_end),
    .string_end (string_end),
    .parse_error(parse_error),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // bytes waiting to be offered, and the results the tokenizer expects
  string_byte_t string_bytes[$];
  result_t      expected_results[$];
  int           pushed = 0;
  int           taken = 0;
  int           mismatches = 0;

  // tokenizer mirror: delimiter setting and per-string parse state
  logic [2:0]   delim_len;
  logic [31:0]  delim_word;
  logic [4:0]   group_depth;
  logic         group_kind [0:STACK_DEPTH-1];  // 1 = curly
  logic [7:0]   held [0:DELIM_MAX-1];           // possible delimiter start
  logic [1:0]   held_n;
  logic         token_open;
  logic         dropping;

  // ---------------------------------------------------------------- tokenizer

  function automatic logic [7:0] delim_at(int k);
    // delimiter bytes past the register read as zero
    return (k < 4) ? delim_word[8*k +: 8] : 8'h00;
  endfunction

  function automatic void emit(logic [7:0] b, logic hb, logic te, logic se, logic pe);
    result_t r;
    r.out_byte    = b;
    r.has_byte    = hb;
    r.token_end   = te;
    r.string_end  = se;
    r.parse_error = pe;
    expected_results.push_back(r);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
    token_open = 1'b1;
  endfunction

  // error mark now, the rest of the string is dropped silently
  function automatic void flag_error();
    emit(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    dropping = 1'b1;
    held_n   = '0;
  endfunction

  function automatic void end_string();
    group_depth = '0;
    held_n      = '0;
    token_open  = 1'b0;
    dropping    = 1'b0;
  endfunction

  function automatic group_outcome_t nest_step(logic [7:0] c);
    logic want_curly;
    if (c == SQ_OPEN || c == CURLY_OPEN) begin
      if (group_depth >= STACK_DEPTH) begin
        flag_error();
        return GROUP_FAULT;
      end
      group_kind[group_depth] = (c == CURLY_OPEN);
      group_depth++;
    end else if (c == SQ_CLOSE || c == CURLY_CLOSE) begin
      want_curly = (c == CURLY_CLOSE);
      if (group_kind[group_depth - 1] != want_curly) begin
        flag_error();
        return GROUP_FAULT;
      end
      group_depth--;
      // the closer that empties the stack is rescanned at top level
      if (group_depth == 0) begin
        return GROUP_CLOSED;
      end
    end
    emit_byte(c);
    return GROUP_HELD;
  endfunction

  function automatic void predict_results(logic [7:0] b, logic last);
    logic [7:0]     seq [0:DELIM_MAX];
    int             n;
    int             pos;
    int             rem;
    int             span;
    int             i;
    logic           is_match;
    group_outcome_t g;
    n    = 0;
    pos  = 0;
    span = (delim_len > DELIM_MAX) ? DELIM_MAX : delim_len;
    if (dropping) begin
      if (last) begin
        emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end_string();
      end
    end else if (span == 0) begin
      // no splitting: held bytes from an earlier setting go out first
      for (i = 0; i < held_n; i++) begin
        emit_byte(held[i]);
      end
      held_n = '0;
      emit_byte(b);
      if (last) begin
        emit(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
        end_string();
      end
    end else begin
      for (i = 0; i < held_n; i++) begin
        seq[n] = held[i];
        n++;
      end
      seq[n] = b;
      n++;
      held_n = '0;
      while (pos < n && !dropping) begin
        if (group_depth > 0) begin
          g = nest_step(seq[pos]);
          if (g == GROUP_HELD) begin
            pos++;
          end
        end else begin
          rem = n - pos;
          is_match = (rem <= span);
          for (i = 0; i < rem; i++) begin
            if (seq[pos + i] != delim_at(i)) begin
              is_match = 1'b0;
            end
          end
          if (is_match && rem == span) begin
            emit(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            token_open = 1'b0;
            pos = n;
          end else if (is_match && !last) begin
            // partial delimiter: hold until the next byte decides
            for (i = 0; i < rem; i++) begin
              held[i] = seq[pos + i];
            end
            held_n = 2'(rem);
            pos = n;
          end else begin
            if (seq[pos] == SQ_OPEN || seq[pos] == CURLY_OPEN) begin
              group_kind[0] = (seq[pos] == CURLY_OPEN);
              group_depth   = 5'd1;
            end
            emit_byte(seq[pos]);
            pos++;
          end
        end
      end
      if (last) begin
        if (dropping || group_depth > 0) begin
          emit(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          emit(8'h00, 1'b0, token_open, 1'b1, 1'b0);
        end
        end_string();
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_byte(logic [7:0] b, logic last);
    string_byte_t item;
    item.data = b;
    item.last = last;
    string_bytes.push_back(item);
    pushed++;
  endfunction

  function automatic void queue_text(string s, logic finish);
    int i;
    for (i = 0; i < s.len(); i++) begin
      push_byte(s[i], finish && (i == s.len() - 1));
    end
  endfunction

  // one string built from pieces: plain bytes, whole and partial
  // delimiters, nested groups (mostly closed again), stray closers and
  // deep runs of openers that can overflow the stack
  task automatic queue_random_string();
    logic [7:0] text[$];
    logic       kinds[$];
    logic       curly;
    logic [7:0] b;
    int         dl;
    int         r;
    int         k;
    int         cnt;
    dl = (delim_len > DELIM_MAX) ? DELIM_MAX : delim_len;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(0, 255));
          text.push_back(b);
        end
      end else if (r < 45 && dl > 0) begin
        for (k = 0; k < dl; k++) begin
          text.push_back(delim_at(k));
        end
      end else if (r < 52 && dl > 1) begin
        cnt = $urandom_range(1, dl - 1);
        for (k = 0; k < cnt; k++) begin
          text.push_back(delim_at(k));
        end
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
      end else if (r < 66) begin
        curly = 1'($urandom_range(0, 1));
        kinds.push_back(curly);
        text.push_back(curly ? CURLY_OPEN : SQ_OPEN);
      end else if (r < 80) begin
        if (kinds.size() > 0) begin
          curly = kinds.pop_back();
          text.push_back(curly ? CURLY_CLOSE : SQ_CLOSE);
        end else begin
          text.push_back($urandom_range(0, 1) ? CURLY_CLOSE : SQ_CLOSE);
        end
      end else if (r < 84) begin
        // closer of random kind, often the wrong one
        curly = 1'($urandom_range(0, 1));
        text.push_back(curly ? CURLY_CLOSE : SQ_CLOSE);
        if (kinds.size() > 0 && kinds[$] == curly) begin
          void'(kinds.pop_back());
        end
      end else if (r < 87) begin
        repeat ($urandom_range(12, 18)) begin
          curly = 1'($urandom_range(0, 1));
          kinds.push_back(curly);
          text.push_back(curly ? CURLY_OPEN : SQ_OPEN);
        end
      end else if (r < 92) begin
        text.push_back("+");
        text.push_back("I");
        text.push_back(SQ_OPEN);
        kinds.push_back(1'b0);
      end else begin
        text.push_back(dl > 0 ? delim_at(0) : "+");
      end
    end
    // most strings close their groups, the rest end unterminated
    if ($urandom_range(0, 9) != 0) begin
      while (kinds.size() > 0) begin
        curly = kinds.pop_back();
        text.push_back(curly ? CURLY_CLOSE : SQ_CLOSE);
      end
    end
    if (text.size() == 0) begin
      b = 8'($urandom_range(0, 255));
      text.push_back(b);
    end
    for (k = 0; k < text.size(); k++) begin
      push_byte(text[k], k == text.size() - 1);
    end
  endtask

  task automatic queue_random(int count);
    int start;
    start = pushed;
    while (pushed - start < count) begin
      queue_random_string();
    end
  endtask

  // wait until every byte is taken and every result seen, then let bytes
  // that cause no result drain out of the pipeline
  task automatic settle();
    while (!(taken == pushed && expected_results.size() == 0)) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_DELIM_LEN: begin
        delim_len = value[2:0];
      end
      REG_DELIM_BYTES: begin
        delim_word = value;
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // gap or stall length: mostly none or short, a few long, with calm
  // stretches where no idling happens at all
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  initial begin : stimulus
    int i;
    delim_len  = DELIM_LEN_RESET;
    delim_word = DELIM_BYTES_RESET;
    for (i = 0; i < STACK_DEPTH; i++) begin
      group_kind[i] = 1'b0;
    end
    end_string();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // comma after reset: empty middle token, a delimiter inside a group,
    // trailing delimiter, mismatched closer, unterminated "+I[" group,
    // byte extremes with a top-level closer
    queue_text("a,,b", 1'b1);
    queue_text("[,],", 1'b1);
    queue_text("{]x", 1'b1);
    queue_text("+I[", 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    queue_text("]", 1'b1);
    queue_random(30);
    settle();

    // two-byte delimiter; phase ends with a comma held mid-string
    write_reg(REG_DELIM_LEN, 32'd2);
    write_reg(REG_DELIM_BYTES, 32'h0000_3B2C);
    queue_text("x;;y,;z", 1'b1);
    queue_text("ab,", 1'b1);
    queue_random(35);
    queue_text("q,", 1'b0);
    settle();

    // splitting off: the held comma passes first, brackets are plain bytes
    write_reg(REG_DELIM_LEN, 32'd0);
    queue_text("[k}", 1'b1);
    queue_random(30);
    settle();

    // over-long length acts as four, all-ones delimiter bytes
    write_reg(REG_DELIM_BYTES, 32'hFFFF_FFFF);
    write_reg(REG_DELIM_LEN, 32'd7);
    repeat (4) push_byte(8'hFF, 1'b0);
    queue_text("a", 1'b0);
    repeat (3) push_byte(8'hFF, 1'b0);
    queue_text("b", 1'b1);
    queue_random(35);
    repeat (3) push_byte(8'hFF, 1'b0);
    settle();

    // shorter length with three bytes held: they are now ordinary bytes
    write_reg(REG_DELIM_LEN, 32'd1);
    queue_text("z", 1'b1);
    queue_random(30);
    settle();

    // three zero bytes as delimiter
    write_reg(REG_DELIM_BYTES, 32'h0000_0000);
    write_reg(REG_DELIM_LEN, 32'd3);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    queue_random(35);
    settle();

    // random four-byte delimiter, long phase so the output hold fills up
    write_reg(REG_DELIM_BYTES, $urandom);
    write_reg(REG_DELIM_LEN, 32'd4);
    queue_random(60);
    settle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  string_byte_t next_item;
  int           in_gap = 0;
  int           in_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // transfer on the input side: predict what this byte causes
      if (in_valid && !in_stall) begin
        predict_results(in_byte, is_last);
        taken++;
      end
      // a held byte stays put until it is taken
      if (!in_valid || !in_stall) begin
        if (in_gap == 0 && string_bytes.size() > 0) begin
          next_item = string_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= next_item.data;
          is_last  <= next_item.last;
          in_gap   = gap_len(in_calm);
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) begin
            in_gap--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int stall_left = 0;
  int out_calm = 0;
  int long_holds = 0;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      // transfer on the output side: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got byte %0h has %b te %b se %b pe %b",
                   $time, out_byte, has_byte, token_end, string_end, parse_error);
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", want.out_byte, out_byte);
          check_field("has_byte", 8'(want.has_byte), 8'(has_byte));
          check_field("token_end", 8'(want.token_end), 8'(token_end));
          check_field("string_end", 8'(want.string_end), 8'(string_end));
          check_field("parse_error", 8'(want.parse_error), 8'(parse_error));
        end
      end
      // long hold while plenty of bytes wait, so the block backs up
      if (long_holds < 2 && stall_left == 0 && string_bytes.size() >= 40) begin
        stall_left = LONG_HOLD;
        long_holds++;
      end
      if (stall_left == 0) begin
        stall_left = gap_len(out_calm);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[nested_delimiter_splitter_unit.f]
rtl/nds_pkg.sv
rtl/nds_rfifo.sv
rtl/nds_parser.sv
rtl/nested_delimiter_splitter_unit.sv
tb/sv/nested_delimiter_splitter_unit_test.sv
